@@ rtl/core/mavt_pkg.sv @@
// ----------------------------------------------------------------------------
// mavt_pkg
// Widths, constants and shared types of the multi-turn angle and velocity
// tracker.
// ----------------------------------------------------------------------------
package mavt_pkg;

    localparam int RAW_BITS   = 14;
    localparam int STAMP_BITS = 24;
    localparam int CPR_W      = 14;
    localparam int TPU_W      = 8;
    localparam int TURN_W     = 16;
    localparam int ANG_W      = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = (CPR_W > TPU_W) ? CPR_W : TPU_W;

    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int QUO_W   = ANG_W - 1;
    localparam int HI_W    = PROD_W - QUO_W;
    localparam int DIV_W   = (STAMP_BITS > CPR_W) ? STAMP_BITS : CPR_W;
    localparam int CNT_W   = $clog2(MUL_W);
    localparam int FRAC_SH = 13;
    localparam int POS_W   = TURN_W + CPR_W + 2;
    localparam int LIM_W   = 27;
    localparam int CMP_W   = (STAMP_BITS > LIM_W) ? STAMP_BITS : LIM_W;
    localparam int JMP_W   = (RAW_BITS + 3 > CPR_W + 2) ? RAW_BITS + 3 : CPR_W + 2;

    // 2*pi in Q3.29
    localparam logic [MUL_W-1:0] TWO_PI_Q29 = 32'hC90F_DAA2;

    localparam logic [CPR_W-1:0] CPR_RESET = CPR_W'(1023);
    localparam logic [TPU_W-1:0] TPU_RESET = TPU_W'(9);

    localparam int US_PER_S = 1000000;
    localparam int LONG_US  = 500000;
    localparam int MS_SCALE = 1000;

    localparam logic [CFG_IDX_W-1:0] CFG_CPR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TPU = CFG_IDX_W'(1);

    localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
    localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};

    typedef struct packed {
        logic done;
        logic sat;
    } t_div_st;

endpackage

@@ rtl/core/mavt_if.sv @@
// ----------------------------------------------------------------------------
// mavt_if
// Item channels and register write channel of the angle and velocity tracker.
// ----------------------------------------------------------------------------
interface mavt_in_if import mavt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [RAW_BITS-1:0]   raw_angle;
    logic [STAMP_BITS-1:0] tick_stamp;

    modport source (output valid, op, raw_angle, tick_stamp, input ready);
    modport sink   (input valid, op, raw_angle, tick_stamp, output ready);
endinterface

interface mavt_out_if import mavt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ANG_W-1:0] full_angle;
    logic signed [ANG_W-1:0] velocity;
    logic                    velocity_valid;

    modport source (output valid, full_angle, velocity, velocity_valid, input ready);
    modport sink   (input valid, full_angle, velocity, velocity_valid, output ready);
endinterface

interface mavt_cfg_if import mavt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

@@ rtl/core/multiturn_angle_velocity_tracker.sv @@
// ----------------------------------------------------------------------------
// multiturn_angle_velocity_tracker
// Unwraps an absolute encoder sample into a multi-turn angle in Q16.16 rad and
// estimates angular velocity in Q16.16 rad/s from the down-counting stamp.
// ----------------------------------------------------------------------------
// Operation: op 0 runs the multiplier and the divider once for the angle; op 1
// runs them once more for the velocity. A saturated quotient skips its divide.
// A new input item is taken only in idle, after the last result has entered the
// output register, so items never overlap in the bit-serial multiplier or divider.
// Reset: synchronous, active low; clears turn count, last sample, last angle
// and last stamp, and loads counts_per_rev 1023 and ticks_per_us 9.
module multiturn_angle_velocity_tracker import mavt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mavt_in_if.sink    i_in,
    mavt_out_if.source o_out,
    mavt_cfg_if.sink   i_cfg
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_POS  = 8'b0000_0010,
        S_AMUL = 8'b0000_0100,
        S_ADIV = 8'b0000_1000,
        S_VSET = 8'b0001_0000,
        S_VMUL = 8'b0010_0000,
        S_VDIV = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [CPR_W-1:0]         r_cpr;
    logic [TPU_W-1:0]         r_tpu;
    logic [RAW_BITS-1:0]      r_last_raw;
    logic signed [TURN_W-1:0] r_turn_count;
    logic signed [ANG_W-1:0]  r_last_full_angle;
    logic [STAMP_BITS-1:0]    r_last_stamp;
    logic                     r_out_valid;

    logic                     r_op;
    logic [STAMP_BITS-1:0]    r_stamp;
    logic                     r_neg;
    logic signed [ANG_W-1:0]  r_angle;
    logic signed [ANG_W-1:0]  r_vel;
    logic [STAMP_BITS-1:0]    r_e;
    logic                     r_long;
    logic signed [ANG_W-1:0]  r_out_angle;
    logic signed [ANG_W-1:0]  r_out_vel;
    logic                     r_out_vv;

    logic [CPR_W-1:0]         w_cpr;
    logic [TPU_W-1:0]         w_tpu;
    logic                     w_in_acc;
    logic                     w_out_free;

    logic signed [RAW_BITS:0] w_jump;
    logic [RAW_BITS:0]        w_jabs;
    logic [JMP_W-1:0]         w_j5;
    logic [JMP_W-1:0]         w_c4;
    logic                     w_wrap;

    logic signed [POS_W-1:0]  w_pos;
    logic [POS_W-1:0]         w_pabs;
    logic signed [ANG_W:0]    w_d;
    logic [ANG_W:0]           w_dabs;
    logic [STAMP_BITS-1:0]    w_e;
    logic [CMP_W-1:0]         w_lim;
    logic                     w_long;
    logic [MUL_W-1:0]         w_kfull;
    logic [PROD_W-1:0]        w_anum;
    logic [PROD_W-1:0]        w_vnum;

    logic                     w_mul_start;
    logic [MUL_W-1:0]         w_mul_a;
    logic [MUL_W-1:0]         w_mul_b;
    logic                     w_mul_done;
    logic [PROD_W-1:0]        w_mul_prod;
    logic                     w_div_start;
    logic [PROD_W-1:0]        w_div_num;
    logic [DIV_W-1:0]         w_div_den;
    t_div_st                  w_div_st;
    logic [QUO_W-1:0]         w_div_quo;

    function automatic logic signed [ANG_W-1:0] f_result(
        input logic             neg,
        input logic             sat,
        input logic [QUO_W-1:0] quo
    );
        logic signed [ANG_W-1:0] mag;
        mag = $signed({1'b0, quo});
        if (sat) begin
            return neg ? $signed({1'b1, {QUO_W{1'b0}}}) : $signed({1'b0, {QUO_W{1'b1}}});
        end
        return neg ? -mag : mag;
    endfunction

    assign w_cpr      = (r_cpr == '0) ? CPR_W'(1) : r_cpr;
    assign w_tpu      = (r_tpu == '0) ? TPU_W'(1) : r_tpu;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign w_jump = $signed({1'b0, i_in.raw_angle}) - $signed({1'b0, r_last_raw});
    assign w_jabs = w_jump[RAW_BITS] ? -w_jump : w_jump;
    assign w_j5   = (JMP_W'(w_jabs) << 2) + JMP_W'(w_jabs);
    assign w_c4   = JMP_W'(w_cpr) << 2;
    assign w_wrap = w_j5 > w_c4;

    assign w_pos  = POS_W'(r_turn_count) * POS_W'($signed({1'b0, w_cpr}))
                  + POS_W'($signed({1'b0, r_last_raw}));
    assign w_pabs = w_pos[POS_W-1] ? -w_pos : w_pos;

    assign w_d    = {r_angle[ANG_W-1], r_angle}
                  - {r_last_full_angle[ANG_W-1], r_last_full_angle};
    assign w_dabs = w_d[ANG_W] ? -w_d : w_d;

    assign w_e     = r_last_stamp - r_stamp;
    assign w_lim   = CMP_W'(w_tpu) * CMP_W'(LONG_US);
    assign w_long  = (w_e == '0) || (CMP_W'(w_e) > w_lim);
    assign w_kfull = MUL_W'(w_tpu) * MUL_W'(US_PER_S);

    assign w_anum = (w_mul_prod + (PROD_W'(w_cpr) << (FRAC_SH - 1))) >> FRAC_SH;
    assign w_vnum = w_mul_prod + (r_long ? '0 : PROD_W'(r_e >> 1));

    always_comb begin
        n_state     = r_state;
        w_mul_start = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_POS;
            end
            S_POS: begin
                w_mul_start = 1'b1;
                w_mul_a     = MUL_W'(w_pabs);
                w_mul_b     = TWO_PI_Q29;
                n_state     = S_AMUL;
            end
            S_AMUL: begin
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    w_div_num   = w_anum;
                    w_div_den   = DIV_W'(w_cpr);
                    n_state     = S_ADIV;
                end
            end
            S_ADIV: begin
                if (w_div_st.done) n_state = r_op ? S_VSET : S_DONE;
            end
            S_VSET: begin
                w_mul_start = 1'b1;
                w_mul_a     = MUL_W'(w_dabs[ANG_W-1:0]);
                w_mul_b     = w_long ? MUL_W'(MS_SCALE) : w_kfull;
                n_state     = S_VMUL;
            end
            S_VMUL: begin
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    w_div_num   = w_vnum;
                    w_div_den   = r_long ? DIV_W'(1) : DIV_W'(r_e);
                    n_state     = S_VDIV;
                end
            end
            S_VDIV: begin
                if (w_div_st.done) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= S_IDLE;
            r_cpr             <= CPR_RESET;
            r_tpu             <= TPU_RESET;
            r_last_raw        <= '0;
            r_turn_count      <= '0;
            r_last_full_angle <= '0;
            r_last_stamp      <= '0;
            r_out_valid       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.idx)
                    CFG_CPR: r_cpr <= i_cfg.data[CPR_W-1:0];
                    CFG_TPU: r_tpu <= i_cfg.data[TPU_W-1:0];
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                r_last_raw <= i_in.raw_angle;
                if (w_wrap) begin
                    if (!w_jump[RAW_BITS]) begin
                        if (r_turn_count != TURN_MIN) r_turn_count <= r_turn_count - TURN_W'(1);
                    end else begin
                        if (r_turn_count != TURN_MAX) r_turn_count <= r_turn_count + TURN_W'(1);
                    end
                end
            end
            if (r_state == S_VSET) begin
                r_last_full_angle <= r_angle;
                r_last_stamp      <= r_stamp;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op    <= i_in.op;
            r_stamp <= i_in.tick_stamp;
        end
        if (r_state == S_POS) begin
            r_neg <= w_pos[POS_W-1];
        end
        if (r_state == S_ADIV && w_div_st.done) begin
            r_angle <= f_result(r_neg, w_div_st.sat, w_div_quo);
            r_vel   <= '0;
        end
        if (r_state == S_VSET) begin
            r_neg  <= w_d[ANG_W];
            r_e    <= w_e;
            r_long <= w_long;
        end
        if (r_state == S_VDIV && w_div_st.done) begin
            r_vel <= f_result(r_neg, w_div_st.sat, w_div_quo);
        end
        if (r_state == S_DONE && w_out_free) begin
            r_out_angle <= r_angle;
            r_out_vel   <= r_vel;
            r_out_vv    <= r_op;
        end
    end

    mavt_smul u_smul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    mavt_sdiv u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_st    (w_div_st),
        .o_quo   (w_div_quo)
    );

    assign o_out.valid          = r_out_valid;
    assign o_out.full_angle     = r_out_angle;
    assign o_out.velocity       = r_out_vel;
    assign o_out.velocity_valid = r_out_vv;

    a_vel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.velocity_valid |-> o_out.velocity == '0)
        else $error("velocity not zero on angle-only item");

    a_turn_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> $stable(r_turn_count))
        else $error("turn count moved without an item");

    a_last_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_VSET |=> $stable(r_last_full_angle) && $stable(r_last_stamp))
        else $error("velocity reference moved outside velocity setup");

    a_done_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && w_out_free |=> r_out_valid && r_state == S_IDLE)
        else $error("finished item not loaded into output register");

endmodule

@@ rtl/core/mavt_smul.sv @@
// ----------------------------------------------------------------------------
// mavt_smul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module mavt_smul import mavt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic              o_done,
    output logic [PROD_W-1:0] o_prod
);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [MUL_W-1:0]  r_a;
    logic [MUL_W-1:0]  r_b;
    logic [PROD_W-1:0] r_acc;
    logic              w_last;

    assign w_last = (r_cnt == CNT_W'(MUL_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_a   <= {r_a[MUL_W-2:0], 1'b0};
            r_acc <= (r_acc << 1) + (r_a[MUL_W-1] ? PROD_W'(r_b) : '0);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ rtl/core/mavt_sdiv.sv @@
// ----------------------------------------------------------------------------
// mavt_sdiv
// Restoring divider, one quotient bit per cycle, with an up-front check for a
// quotient beyond the signed 32-bit range.
// ----------------------------------------------------------------------------
module mavt_sdiv import mavt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_num,
    input  logic [DIV_W-1:0]  i_den,
    output t_div_st           o_st,
    output logic [QUO_W-1:0]  o_quo
);

    logic             r_busy;
    t_div_st          r_st;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W:0]   r_rem;
    logic [QUO_W-1:0] r_quo;
    logic [DIV_W-1:0] r_den;

    logic             w_sat;
    logic [DIV_W:0]   w_trial;
    logic             w_ge;
    logic             w_last;

    assign w_sat   = i_num[PROD_W-1:QUO_W] >= HI_W'(i_den);
    assign w_trial = {r_rem[DIV_W-1:0], r_quo[QUO_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_last  = (r_cnt == CNT_W'(QUO_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_st   <= '0;
            r_cnt  <= '0;
        end else begin
            r_st.done <= 1'b0;
            if (i_start) begin
                r_cnt  <= '0;
                r_st.sat <= w_sat;
                if (w_sat) begin
                    r_st.done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (w_last) begin
                    r_busy    <= 1'b0;
                    r_st.done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= i_num[QUO_W +: DIV_W+1];
            r_quo <= i_num[QUO_W-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
            r_quo <= {r_quo[QUO_W-2:0], w_ge};
        end
    end

    assign o_st  = r_st;
    assign o_quo = r_quo;

endmodule
